FILE: sv/assert_macros.svh
// Assertion macros shared by the stereo echo RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define SCE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked check that also runs during reset.
`define SCE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/sce_pkg.sv
// Package for the stereo cross-feedback echo: payload and config types,
// widths, register indexes and the saturation helper. No dependencies.
package sce_pkg;

  localparam int SAMPLE_WIDTH    = 24;
  localparam int DELAY_DEPTH_DEF = 32768;
  localparam int QUEUE_DEPTH     = 2;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int DELAY_W     = 15;
  localparam int AMOUNT_W    = 8;

  localparam int COEF_W      = 18;
  localparam int PROD_W      = SAMPLE_WIDTH + COEF_W;
  localparam int ACC_W       = PROD_W + 2;
  localparam int MIX_COEF_W  = 10;
  localparam int MIX_PROD_W  = SAMPLE_WIDTH + MIX_COEF_W;
  localparam int MIX_ACC_W   = MIX_PROD_W + 1;
  localparam int FB_SHIFT    = 16;
  localparam int MIX_SHIFT   = 8;

  localparam logic signed [ACC_W-1:0] SAT_HI =
    ACC_W'((longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DELAY    = 4'd0,
    REG_FEEDBACK = 4'd1,
    REG_MIX      = 4'd2,
    REG_CROSS    = 4'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] left_in;
    logic signed [SAMPLE_WIDTH-1:0] right_in;
    logic                           block_end;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] left_out;
    logic signed [SAMPLE_WIDTH-1:0] right_out;
    logic                           block_end_out;
  } out_item_t;

  typedef struct packed {
    logic [DELAY_W-1:0]  delay_samples;
    logic [AMOUNT_W-1:0] feedback_amount;
    logic [AMOUNT_W-1:0] mix_amount;
    logic [AMOUNT_W-1:0] cross_amount;
  } cfg_t;

  function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [ACC_W-1:0] c;
    begin
      c = v;
      if (v > SAT_HI) c = SAT_HI;
      if (v < SAT_LO) c = SAT_LO;
      return c[SAMPLE_WIDTH-1:0];
    end
  endfunction

endpackage

FILE: sv/sce_queue.sv
// Short FIFO between the front and back ends of the stereo echo.
// Generic width; depth from sce_pkg via the top level.
`include "assert_macros.svh"

module sce_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] head_r, tail_r;
  logic [CNT_W-1:0] count_r;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = slot_r[head_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[tail_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        tail_r <= (tail_r == PTR_W'(DEPTH - 1)) ? '0 : tail_r + PTR_W'(1);
      end
      if (pop) begin
        head_r <= (head_r == PTR_W'(DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  `SCE_ASSERT(a_no_push_full, clk, rst_n, push |-> (count_r != CNT_W'(DEPTH)), "push into full queue")
  `SCE_ASSERT(a_no_pop_empty, clk, rst_n, pop |-> (count_r != '0), "pop from empty queue")

endmodule

FILE: sv/sce_front.sv
// Front end of the stereo echo: takes frames, tags each with its write and
// read positions and whether the read hits a written entry. Uses sce_pkg.
`include "assert_macros.svh"

module sce_front #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  sce_pkg::in_item_t        in_data,
  input  logic [sce_pkg::DELAY_W-1:0] delay_samples,
  input  logic                     q_full,
  output logic                     q_push,
  output logic [$bits(sce_pkg::in_item_t)+2*AW:0] q_data
);

  localparam int CW = ((AW > sce_pkg::DELAY_W) ? AW : sce_pkg::DELAY_W) + 1;

  logic [AW-1:0] wp_r;
  logic          wrapped_r;
  logic [CW-1:0] d_ext;
  logic [AW-1:0] d_clamp;
  logic [AW-1:0] rp;
  logic [AW:0]   rp_wrap;
  logic          hit;
  logic          accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept;

  always_comb begin
    d_ext = CW'(delay_samples);
    if (d_ext > CW'(DEPTH - 1)) begin
      d_clamp = AW'(DEPTH - 1);
    end else begin
      d_clamp = d_ext[AW-1:0];
    end
    rp_wrap = {1'b0, wp_r} + (AW + 1)'(DEPTH) - {1'b0, d_clamp};
    if (wp_r >= d_clamp) begin
      rp = wp_r - d_clamp;
    end else begin
      rp = rp_wrap[AW-1:0];
    end
    // entries below the write pointer are written until the first wrap
    hit = wrapped_r || (rp < wp_r);
  end

  assign q_data = {in_data, wp_r, rp, hit};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      wrapped_r <= 1'b0;
    end else if (accept) begin
      if (wp_r == AW'(DEPTH - 1)) begin
        wp_r      <= '0;
        wrapped_r <= 1'b1;
      end else begin
        wp_r <= wp_r + AW'(1);
      end
    end
  end

  `SCE_ASSERT(a_wp_step, clk, rst_n, (accept && (wp_r != AW'(DEPTH - 1))) |=> (wp_r == $past(wp_r) + AW'(1)), "write pointer did not advance")

endmodule

FILE: sv/sce_back.sv
// Back end of the stereo echo: delay memories, feedback and mix arithmetic,
// write-back and output register. Uses sce_pkg; fed by sce_queue.
`include "assert_macros.svh"

module sce_back #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sce_pkg::cfg_t       cfg,
  input  logic                q_valid,
  input  logic [$bits(sce_pkg::in_item_t)+2*AW:0] q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output sce_pkg::out_item_t  out_data
);

  localparam int SW    = sce_pkg::SAMPLE_WIDTH;
  localparam int IW    = $bits(sce_pkg::in_item_t);
  localparam int PW    = sce_pkg::PROD_W;
  localparam int ACW   = sce_pkg::ACC_W;
  localparam int CFW   = sce_pkg::COEF_W;
  localparam int MCW   = sce_pkg::MIX_COEF_W;
  localparam int MPW   = sce_pkg::MIX_PROD_W;
  localparam int MAW   = sce_pkg::MIX_ACC_W;

  typedef enum logic [2:0] {B_IDLE, B_READ, B_MUL, B_SUM, B_WB} bstate_t;

  bstate_t state_r;

  logic signed [SW-1:0] mem_l [DEPTH];
  logic signed [SW-1:0] mem_r [DEPTH];
  logic signed [SW-1:0] rdl_r, rdr_r;

  sce_pkg::in_item_t ent_item_r;
  logic [AW-1:0]     ent_wp_r, ent_rp_r;
  logic              ent_hit_r;

  logic [8:0]            inv_c, inv_f;
  logic [CFW-1:0]        self_in_u, cross_in_u, back_mag_u, cross_back_u;
  logic signed [CFW-1:0] c_self_in_r, c_cross_in_r, c_self_back_r, c_cross_back_r;
  logic signed [MCW-1:0] c_wet_r, c_dry_r;

  logic signed [SW-1:0]  dl, dr;
  logic signed [PW-1:0]  pl_si_r, pr_ci_r, pdl_sb_r, pdr_cb_r;
  logic signed [PW-1:0]  pr_si_r, pl_ci_r, pdr_sb_r, pdl_cb_r;
  logic signed [MPW-1:0] ml_dry_r, mdl_wet_r, mr_dry_r, mdr_wet_r;
  logic signed [ACW-1:0] acc_l, acc_r;
  logic signed [MAW-1:0] macc_l, macc_r;

  logic signed [SW-1:0]  new_l_r, new_r_r, res_l_r, res_r_r;
  logic                  out_valid_r;
  sce_pkg::out_item_t    out_data_r;
  logic                  can_go, wb_fire;

  assign can_go  = !out_valid_r || out_ready;
  assign wb_fire = (state_r == B_WB) && can_go;
  assign q_pop   = q_valid && ((state_r == B_IDLE) || wb_fire);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // coefficients are derived from the config registers and registered
  always_comb begin
    inv_c        = 9'd256 - {1'b0, cfg.cross_amount};
    inv_f        = 9'd256 - {1'b0, cfg.feedback_amount};
    self_in_u    = CFW'(inv_c) * CFW'(inv_f);
    cross_in_u   = CFW'(cfg.cross_amount) * CFW'(inv_f);
    back_mag_u   = CFW'(inv_c) * CFW'(cfg.feedback_amount);
    cross_back_u = CFW'(cfg.cross_amount) * CFW'(cfg.feedback_amount);
  end

  always_ff @(posedge clk) begin
    c_self_in_r    <= signed'(self_in_u);
    c_cross_in_r   <= signed'(cross_in_u);
    c_self_back_r  <= -signed'(back_mag_u);
    c_cross_back_r <= signed'(cross_back_u);
    c_wet_r        <= signed'({2'b00, cfg.mix_amount});
    c_dry_r        <= MCW'(256) - signed'({2'b00, cfg.mix_amount});
  end

  always_ff @(posedge clk) begin
    if (wb_fire) begin
      mem_l[ent_wp_r] <= new_l_r;
      mem_r[ent_wp_r] <= new_r_r;
    end
    rdl_r <= mem_l[ent_rp_r];
    rdr_r <= mem_r[ent_rp_r];
  end

  assign dl = ent_hit_r ? rdl_r : '0;
  assign dr = ent_hit_r ? rdr_r : '0;

  always_comb begin
    acc_l  = ACW'(pl_si_r) + ACW'(pr_ci_r) + ACW'(pdl_sb_r) + ACW'(pdr_cb_r);
    acc_r  = ACW'(pr_si_r) + ACW'(pl_ci_r) + ACW'(pdr_sb_r) + ACW'(pdl_cb_r);
    macc_l = MAW'(ml_dry_r) + MAW'(mdl_wet_r);
    macc_r = MAW'(mr_dry_r) + MAW'(mdr_wet_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (wb_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (q_pop) begin
            state_r <= B_READ;
          end
        end
        B_READ: begin
          state_r <= B_MUL;
        end
        B_MUL: begin
          pl_si_r   <= PW'(ent_item_r.left_in) * PW'(c_self_in_r);
          pr_ci_r   <= PW'(ent_item_r.right_in) * PW'(c_cross_in_r);
          pdl_sb_r  <= PW'(dl) * PW'(c_self_back_r);
          pdr_cb_r  <= PW'(dr) * PW'(c_cross_back_r);
          pr_si_r   <= PW'(ent_item_r.right_in) * PW'(c_self_in_r);
          pl_ci_r   <= PW'(ent_item_r.left_in) * PW'(c_cross_in_r);
          pdr_sb_r  <= PW'(dr) * PW'(c_self_back_r);
          pdl_cb_r  <= PW'(dl) * PW'(c_cross_back_r);
          ml_dry_r  <= MPW'(ent_item_r.left_in) * MPW'(c_dry_r);
          mdl_wet_r <= MPW'(dl) * MPW'(c_wet_r);
          mr_dry_r  <= MPW'(ent_item_r.right_in) * MPW'(c_dry_r);
          mdr_wet_r <= MPW'(dr) * MPW'(c_wet_r);
          state_r   <= B_SUM;
        end
        B_SUM: begin
          new_l_r <= sce_pkg::sat_sample(acc_l >>> sce_pkg::FB_SHIFT);
          new_r_r <= sce_pkg::sat_sample(acc_r >>> sce_pkg::FB_SHIFT);
          res_l_r <= sce_pkg::sat_sample(ACW'(macc_l >>> sce_pkg::MIX_SHIFT));
          res_r_r <= sce_pkg::sat_sample(ACW'(macc_r >>> sce_pkg::MIX_SHIFT));
          state_r <= B_WB;
        end
        B_WB: begin
          if (can_go) begin
            out_data_r.left_out      <= res_l_r;
            out_data_r.right_out     <= res_r_r;
            out_data_r.block_end_out <= ent_item_r.block_end;
            state_r                  <= q_pop ? B_READ : B_IDLE;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
      if (q_pop) begin
        ent_item_r <= sce_pkg::in_item_t'(q_data[2*AW+IW:2*AW+1]);
        ent_wp_r   <= q_data[2*AW:AW+1];
        ent_rp_r   <= q_data[AW:1];
        ent_hit_r  <= q_data[0];
      end
    end
  end

  `SCE_ASSERT(a_wb_shows, clk, rst_n, wb_fire |=> out_valid_r, "write-back without result")
  `SCE_ASSERT(a_pop_when_free, clk, rst_n, q_pop |-> ((state_r == B_IDLE) || (state_r == B_WB)), "pop while busy")
  `SCE_ASSERT_ALWAYS(a_reset_out, clk, !rst_n |=> !out_valid_r, "result valid after reset")

endmodule

FILE: sv/stereo_cross_feedback_echo.sv
// Stereo cross-feedback echo, one stereo frame per transfer, one result per
// frame. A frame is taken into a two-entry queue while the queue has room; the
// back end then takes it through memory read, multiply, sum and saturate and
// write-back, and takes no new frame until the last one's write-back, which
// waits while the output stalls; this is set by the read-modify-write of the
// delay memory. Delay entries not yet written read as zero through a fill flag,
// so there is no clearing pass after reset. Config writes are always ready.
// Uses sce_pkg, sce_front, sce_queue and sce_back.

module stereo_cross_feedback_echo #(
  parameter int DELAY_DEPTH = sce_pkg::DELAY_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  sce_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output sce_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sce_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [sce_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int QW = $bits(sce_pkg::in_item_t) + 2 * AW + 1;

  sce_pkg::cfg_t  cfg_r;
  logic           q_full, q_push, q_pop, q_not_empty;
  logic [QW-1:0]  q_in, q_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sce_pkg::REG_DELAY:    cfg_r.delay_samples   <= cfg_data[sce_pkg::DELAY_W-1:0];
        sce_pkg::REG_FEEDBACK: cfg_r.feedback_amount <= cfg_data[sce_pkg::AMOUNT_W-1:0];
        sce_pkg::REG_MIX:      cfg_r.mix_amount      <= cfg_data[sce_pkg::AMOUNT_W-1:0];
        sce_pkg::REG_CROSS:    cfg_r.cross_amount    <= cfg_data[sce_pkg::AMOUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  sce_front #(
    .DEPTH (DELAY_DEPTH),
    .AW    (AW)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .delay_samples (cfg_r.delay_samples),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_in)
  );

  sce_queue #(
    .WIDTH (QW),
    .DEPTH (sce_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_out)
  );

  sce_back #(
    .DEPTH (DELAY_DEPTH),
    .AW    (AW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_not_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for stereo_cross_feedback_echo: directed and random frames and echo settings,
// outputs checked against an in-bench echo predictor. Depends on sce_pkg and the RTL.

module tb;

  localparam int ECHO_DEPTH   = sce_pkg::DELAY_DEPTH_DEF;
  localparam int SW           = sce_pkg::SAMPLE_WIDTH;
  localparam int DRAIN_CYCLES = 24;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_FRAMES  = 205;
  localparam int LONG_HOLD_AT  = 400;
  localparam int LONG_HOLD_LEN = 300;

  typedef struct packed {
    logic [sce_pkg::CFG_INDEX_W-1:0] idx;
    logic [sce_pkg::CFG_DATA_W-1:0]  data;
  } reg_write_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  sce_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sce_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [sce_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [sce_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  stereo_cross_feedback_echo uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic signed [SW-1:0] echo_left [ECHO_DEPTH];
  logic signed [SW-1:0] echo_right [ECHO_DEPTH];
  int unsigned echo_wr_pos = 0;
  logic [sce_pkg::DELAY_W-1:0] delay_setting = '0;
  logic [sce_pkg::AMOUNT_W-1:0] feedback_setting = '0;
  logic [sce_pkg::AMOUNT_W-1:0] mix_setting = '0;
  logic [sce_pkg::AMOUNT_W-1:0] xfeed_setting = '0;

  sce_pkg::in_item_t frames_to_send[$];
  sce_pkg::out_item_t expected_frames[$];
  reg_write_t reg_writes_pending[$];

  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  int unsigned frames_sent = 0;
  int unsigned results_seen = 0;
  int unsigned reg_writes_done = 0;
  int unsigned settings_used = 0;
  int unsigned mismatch_count = 0;
  bit quiet_end = 1'b0;
  sce_pkg::out_item_t want;

  function automatic logic signed [SW-1:0] clip_sample(input longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (SW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[SW-1:0];
  endfunction

  function automatic void apply_reg_write(input logic [sce_pkg::CFG_INDEX_W-1:0] idx,
                                          input logic [sce_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      sce_pkg::REG_DELAY:    delay_setting = data[sce_pkg::DELAY_W-1:0];
      sce_pkg::REG_FEEDBACK: feedback_setting = data[sce_pkg::AMOUNT_W-1:0];
      sce_pkg::REG_MIX:      mix_setting = data[sce_pkg::AMOUNT_W-1:0];
      sce_pkg::REG_CROSS:    xfeed_setting = data[sce_pkg::AMOUNT_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic sce_pkg::out_item_t predict_echo_frame(input sce_pkg::in_item_t frame);
    longint l, r, dl, dr, f, c, m;
    longint k_self_in, k_cross_in, k_self_back, k_cross_back, acc_l, acc_r;
    int unsigned d, rp;
    sce_pkg::out_item_t res;
    l = longint'(frame.left_in);
    r = longint'(frame.right_in);
    d = 32'(delay_setting);
    if (d > ECHO_DEPTH - 1) d = ECHO_DEPTH - 1;
    rp = (echo_wr_pos >= d) ? echo_wr_pos - d : echo_wr_pos + ECHO_DEPTH - d;
    dl = longint'(echo_left[rp]);
    dr = longint'(echo_right[rp]);
    f = longint'(feedback_setting);
    c = longint'(xfeed_setting);
    m = longint'(mix_setting);
    k_self_in    = (256 - c) * (256 - f);
    k_cross_in   = c * (256 - f);
    k_self_back  = (c - 256) * f;
    k_cross_back = c * f;
    acc_l = l * k_self_in + r * k_cross_in + dl * k_self_back + dr * k_cross_back;
    acc_r = r * k_self_in + l * k_cross_in + dr * k_self_back + dl * k_cross_back;
    echo_left[echo_wr_pos]  = clip_sample(acc_l >>> sce_pkg::FB_SHIFT);
    echo_right[echo_wr_pos] = clip_sample(acc_r >>> sce_pkg::FB_SHIFT);
    echo_wr_pos = (echo_wr_pos + 1) % ECHO_DEPTH;
    res.left_out      = clip_sample((l * (256 - m) + dl * m) >>> sce_pkg::MIX_SHIFT);
    res.right_out     = clip_sample((r * (256 - m) + dr * m) >>> sce_pkg::MIX_SHIFT);
    res.block_end_out = frame.block_end;
    return res;
  endfunction

  function automatic logic signed [SW-1:0] pick_sample();
    logic [31:0] raw;
    raw = $urandom();
    case ($urandom_range(0, 7))
      0: return {1'b0, {(SW-1){1'b1}}};
      1: return {1'b1, {(SW-1){1'b0}}};
      2: return SW'($signed($urandom_range(0, 511)) - 256);
      default: return raw[SW-1:0];
    endcase
  endfunction

  function automatic int unsigned pick_amount();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // driver: config channel and frame channel
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_valid <= 1'b0;
      in_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        apply_reg_write(cfg_index, cfg_data);
        reg_writes_done++;
      end
      if (!cfg_valid || cfg_ready) begin
        if (reg_writes_pending.size() != 0) begin
          cfg_index <= reg_writes_pending[0].idx;
          cfg_data <= reg_writes_pending[0].data;
          void'(reg_writes_pending.pop_front());
          cfg_valid <= 1'b1;
        end else begin
          cfg_valid <= 1'b0;
        end
      end

      if (in_valid && in_ready) begin
        expected_frames.push_back(predict_echo_frame(in_data));
        frames_sent++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (frames_to_send.size() != 0) begin
          in_data <= frames_to_send.pop_front();
          in_valid <= 1'b1;
          if (!quiet_end && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 10);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: result checks and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_frames.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        end else begin
          want = expected_frames.pop_front();
          if (out_data.left_out !== want.left_out) begin
            mismatch_count++;
            $display("%0t: left_out expected %0d actual %0d", $time,
                     want.left_out, out_data.left_out);
          end
          if (out_data.right_out !== want.right_out) begin
            mismatch_count++;
            $display("%0t: right_out expected %0d actual %0d", $time,
                     want.right_out, out_data.right_out);
          end
          if (out_data.block_end_out !== want.block_end_out) begin
            mismatch_count++;
            $display("%0t: block_end_out expected %b actual %b", $time,
                     want.block_end_out, out_data.block_end_out);
          end
        end
        if (results_seen == LONG_HOLD_AT) recv_stall = LONG_HOLD_LEN;
      end
      if (recv_stall != 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else if (!quiet_end && $urandom_range(0, 7) == 0) begin
        recv_stall = $urandom_range(1, 10) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic settle();
    while (frames_to_send.size() != 0 || in_valid || expected_frames.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic queue_reg(input logic [sce_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [sce_pkg::CFG_DATA_W-1:0] data);
    reg_write_t w;
    w.idx = idx;
    w.data = data;
    reg_writes_pending.push_back(w);
  endtask

  task automatic program_echo(input logic [sce_pkg::CFG_DATA_W-1:0] delay_word,
                              input int unsigned fb,
                              input int unsigned mix, input int unsigned xfeed);
    logic [7:0] junk;
    settle();
    junk = 8'($urandom_range(0, 255));
    queue_reg(sce_pkg::REG_DELAY, delay_word);
    queue_reg(sce_pkg::REG_FEEDBACK, {junk, fb[7:0]});
    queue_reg(sce_pkg::REG_MIX, {~junk, mix[7:0]});
    queue_reg(sce_pkg::REG_CROSS, {junk ^ 8'h5a, xfeed[7:0]});
    // unmapped index must leave all settings alone
    queue_reg(sce_pkg::CFG_INDEX_W'($urandom_range(sce_pkg::REG_CROSS + 1,
                                                   2**sce_pkg::CFG_INDEX_W - 1)),
              sce_pkg::CFG_DATA_W'($urandom_range(0, 65535)));
    while (reg_writes_pending.size() != 0 || cfg_valid) @(negedge clk);
    settings_used++;
  endtask

  task automatic queue_frame(input logic signed [SW-1:0] l,
                             input logic signed [SW-1:0] r, input logic be);
    sce_pkg::in_item_t fr;
    fr.left_in = l;
    fr.right_in = r;
    fr.block_end = be;
    frames_to_send.push_back(fr);
  endtask

  task automatic queue_corner_frames();
    logic signed [SW-1:0] s_max, s_min;
    s_max = {1'b0, {(SW-1){1'b1}}};
    s_min = {1'b1, {(SW-1){1'b0}}};
    queue_frame(s_max, s_min, 1'b0);
    queue_frame(s_min, s_max, 1'b1);
    queue_frame(s_max, s_max, 1'b0);
    queue_frame(s_min, s_min, 1'b1);
    queue_frame('0, '0, 1'b0);
    queue_frame(SW'(-1), SW'(1), 1'b1);
    queue_frame(s_max, s_min, 1'b0);
    queue_frame(pick_sample(), pick_sample(), 1'b1);
  endtask

  initial begin
    logic [sce_pkg::CFG_DATA_W-1:0] dw;
    for (int i = 0; i < ECHO_DEPTH; i++) begin
      echo_left[i] = '0;
      echo_right[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: zero delay and dry only, then full wet/feedback/cross, then half wet/feedback, no cross
    program_echo(16'h0000, 0, 0, 0);
    queue_corner_frames();
    program_echo(16'h8003, 255, 255, 255);
    queue_corner_frames();
    program_echo(16'h0001, 128, 128, 0);
    queue_corner_frames();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 3) dw = 16'hffff;
      else if ($urandom_range(0, 3) == 0) dw = sce_pkg::CFG_DATA_W'($urandom_range(41, 1200));
      else dw = sce_pkg::CFG_DATA_W'($urandom_range(0, 40));
      dw[15] = 1'($urandom_range(0, 1));
      program_echo(dw, pick_amount(), pick_amount(), pick_amount());
      if (p == RANDOM_PHASES - 1) quiet_end = 1'b1;
      for (int k = 0; k < PHASE_FRAMES; k++)
        queue_frame(pick_sample(), pick_sample(), $urandom_range(0, 15) == 0);
    end

    settle();
    $display("Covered %0d frames and %0d results over %0d echo settings (%0d register writes).",
             frames_sent, results_seen, settings_used, reg_writes_done);
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
